@@ rtl/core/rl7_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rl7_pkg
// Shared types and constants of the RL7 run-length line decoder.
// ----------------------------------------------------------------------------
package rl7_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COLOR_W  = 7;
  localparam int unsigned FIELD_W  = 9;
  localparam int unsigned RUN_FLAG_BIT = 7;

  // Decoupling queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // One classified item: a literal pixel or a run with its length byte.
  typedef struct packed {
    logic               is_run;
    logic [COLOR_W-1:0] color;
    logic [BYTE_W-1:0]  len_byte;
  } rl7_item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic      valid;
    rl7_item_t item;
  } rl7_head_t;

endpackage

@@ rtl/core/rl7_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rl7_front
// Accepts stream bytes, pairs run markers with their length bytes and pushes
// one classified item per result into the queue.
// ----------------------------------------------------------------------------
module rl7_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rl7_pkg::BYTE_W-1:0]   in_code_byte,
  input  logic                         q_full,
  output logic                         q_push,
  output rl7_pkg::rl7_item_t           q_item
);

  logic                         awaiting_r, awaiting_nxt;
  logic [rl7_pkg::COLOR_W-1:0]  held_color_r, held_color_nxt;
  logic                         accept;
  logic                         is_marker;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign is_marker = in_code_byte[rl7_pkg::RUN_FLAG_BIT];

  always_comb begin
    awaiting_nxt     = awaiting_r;
    held_color_nxt   = held_color_r;
    q_push           = 1'b0;
    q_item.is_run    = 1'b0;
    q_item.color     = in_code_byte[rl7_pkg::COLOR_W-1:0];
    q_item.len_byte  = in_code_byte;
    if (accept) begin
      if (awaiting_r) begin
        // Any byte after a marker is its length, bit 7 included.
        awaiting_nxt  = 1'b0;
        q_push        = 1'b1;
        q_item.is_run = 1'b1;
        q_item.color  = held_color_r;
      end else if (is_marker) begin
        awaiting_nxt   = 1'b1;
        held_color_nxt = in_code_byte[rl7_pkg::COLOR_W-1:0];
      end else begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r   <= 1'b0;
      held_color_r <= '0;
    end else begin
      awaiting_r   <= awaiting_nxt;
      held_color_r <= held_color_nxt;
    end
  end

endmodule

@@ rtl/core/rl7_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rl7_queue
// Two-entry queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module rl7_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rl7_pkg::rl7_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output rl7_pkg::rl7_head_t  head
);

  rl7_pkg::rl7_item_t                mem_r [rl7_pkg::QUEUE_DEPTH];
  logic [rl7_pkg::QPTR_W-1:0]        wptr_r, wptr_nxt;
  logic [rl7_pkg::QPTR_W-1:0]        rptr_r, rptr_nxt;
  logic [rl7_pkg::QCNT_W-1:0]        count_r, count_nxt;
  logic                              do_push;
  logic                              do_pop;

  assign full       = (count_r == rl7_pkg::QCNT_W'(rl7_pkg::QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_pop  ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/core/rl7_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rl7_back
// Tracks the raster position, clips each run to the line and holds the
// finished run descriptor in the output register.
// ----------------------------------------------------------------------------
module rl7_back #(
  parameter int unsigned LINE_WIDTH = 384,
  parameter int unsigned LINE_COUNT = 280
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rl7_pkg::rl7_head_t            head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rl7_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic [rl7_pkg::FIELD_W-1:0]   out_run_length,
  output logic [rl7_pkg::FIELD_W-1:0]   out_start_column,
  output logic [rl7_pkg::FIELD_W-1:0]   out_line_row,
  output logic                          out_line_done,
  output logic                          out_frame_done
);

  localparam int unsigned COL_W = $clog2(LINE_WIDTH);
  localparam int unsigned LEN_W = $clog2(LINE_WIDTH + 1);
  localparam int unsigned ROW_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam int unsigned CMP_W = (LEN_W > rl7_pkg::BYTE_W) ? LEN_W : rl7_pkg::BYTE_W;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [rl7_pkg::COLOR_W-1:0]  color_r;
  logic [rl7_pkg::FIELD_W-1:0]  len_out_r;
  logic [rl7_pkg::FIELD_W-1:0]  start_out_r;
  logic [rl7_pkg::FIELD_W-1:0]  row_out_r;
  logic                         ldone_r;
  logic                         fdone_r;

  logic [LEN_W-1:0]   left;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   col_sum;
  logic               line_end;
  logic               frame_end;
  logic [CMP_W-1:0]   byte_ext;
  logic [CMP_W-1:0]   left_ext;

  assign pop = head.valid && (!out_valid_r || out_ready);

  always_comb begin
    left     = LEN_W'(LINE_WIDTH) - LEN_W'(col_r);
    byte_ext = CMP_W'(head.item.len_byte);
    left_ext = CMP_W'(left);
    if (!head.item.is_run) begin
      len = LEN_W'(1);
    end else if (byte_ext == '0 || byte_ext > left_ext) begin
      // Zero fills the line; an overlong run is clipped at the line end.
      len = left;
    end else begin
      len = LEN_W'(head.item.len_byte);
    end
    col_sum   = LEN_W'(col_r) + len;
    line_end  = (col_sum == LEN_W'(LINE_WIDTH));
    frame_end = line_end && (row_r == ROW_W'(LINE_COUNT - 1));

    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      out_valid_nxt = 1'b1;
      if (line_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = COL_W'(col_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      color_r     <= head.item.color;
      len_out_r   <= rl7_pkg::FIELD_W'(len);
      start_out_r <= rl7_pkg::FIELD_W'(col_r);
      row_out_r   <= rl7_pkg::FIELD_W'(row_r);
      ldone_r     <= line_end;
      fdone_r     <= frame_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_color  = color_r;
  assign out_run_length   = len_out_r;
  assign out_start_column = start_out_r;
  assign out_line_row     = row_out_r;
  assign out_line_done    = ldone_r;
  assign out_frame_done   = fdone_r;

endmodule

@@ rtl/core/rl7_run_length_line_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rl7_run_length_line_decoder
// RL7 run-length decoder that turns a byte stream into run descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel takes one encoded byte per beat. A byte with bit 7 clear
//   is one pixel; a byte with bit 7 set is a run marker and the next byte is
//   the run length (zero fills the line, longer runs are clipped at the line
//   end). Each pixel or run gives one beat on the out_ channel with color,
//   length, start column, row and line and frame end flags. Markers give no
//   beat. After the last row the position wraps to row 0.
//   Each item is queued, then held in the output register. The block takes
//   one byte per cycle while in_ready is high; the front end classifies
//   bytes, a two-entry queue decouples it from the back end, whose position
//   update and output register retire one item per cycle when not stalled.
//   When the receiver stalls, the output register holds its beat and the
//   queue fills; in_ready drops once the queue holds two items.
//   Synchronous reset clears the position to row 0, column 0, drops any
//   pending marker and empties the queue and the output register.
// ----------------------------------------------------------------------------
module rl7_run_length_line_decoder #(
  parameter int unsigned LINE_WIDTH = 384,
  parameter int unsigned LINE_COUNT = 280
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rl7_pkg::BYTE_W-1:0]    in_code_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rl7_pkg::COLOR_W-1:0]   out_pixel_color,
  output logic [rl7_pkg::FIELD_W-1:0]   out_run_length,
  output logic [rl7_pkg::FIELD_W-1:0]   out_start_column,
  output logic [rl7_pkg::FIELD_W-1:0]   out_line_row,
  output logic                          out_line_done,
  output logic                          out_frame_done
);

  logic                 q_full;
  logic                 q_push;
  logic                 q_pop;
  rl7_pkg::rl7_item_t   q_item;
  rl7_pkg::rl7_head_t   q_head;

  rl7_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_code_byte (in_code_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  rl7_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  rl7_back #(
    .LINE_WIDTH (LINE_WIDTH),
    .LINE_COUNT (LINE_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_color  (out_pixel_color),
    .out_run_length   (out_run_length),
    .out_start_column (out_start_column),
    .out_line_row     (out_line_row),
    .out_line_done    (out_line_done),
    .out_frame_done   (out_frame_done)
  );

endmodule

@@ test/rl7_run_length_line_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rl7_run_length_line_decoder_tb
// Self-checking testbench for the RL7 run-length line decoder.
// ----------------------------------------------------------------------------
// Code bytes are sent on the in_ channel, mostly with random gaps, while the out_
// channel mostly stalls at random. A predictor in the testbench decodes every
// accepted byte and queues the run it should produce. Each run beat is then
// checked field by field against the oldest queued run. Directed tests cover
// literal pixels, zero-length, overlong and exact line-end runs, and length
// bytes with bit 7 set. A full frame of line-filling runs checks the wrap to
// row 0. A random stream of mixed pixels and runs follows.
// ----------------------------------------------------------------------------
module rl7_run_length_line_decoder_tb;

  localparam int unsigned LW = 384;
  localparam int unsigned LC = 280;

  typedef struct {
    logic [rl7_pkg::COLOR_W-1:0] color;
    logic [rl7_pkg::FIELD_W-1:0] length;
    logic [rl7_pkg::FIELD_W-1:0] start;
    logic [rl7_pkg::FIELD_W-1:0] row;
    logic                        line_done;
    logic                        frame_done;
  } run_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [rl7_pkg::BYTE_W-1:0]  in_code_byte = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [rl7_pkg::COLOR_W-1:0] out_pixel_color;
  logic [rl7_pkg::FIELD_W-1:0] out_run_length;
  logic [rl7_pkg::FIELD_W-1:0] out_start_column;
  logic [rl7_pkg::FIELD_W-1:0] out_line_row;
  logic                        out_line_done;
  logic                        out_frame_done;

  // Decoder state as the predictor sees it.
  bit                          awaiting_len = 1'b0;
  logic [rl7_pkg::COLOR_W-1:0] held_color = '0;
  int unsigned                 col_pos = 0;
  int unsigned                 row_pos = 0;

  run_t expected_runs[$];
  int   errors = 0;
  int   bytes_sent = 0;
  int   runs_checked = 0;
  int   lines_predicted = 0;
  int   frames_predicted = 0;
  bit   in_gaps_on = 1'b0;
  bit   out_stalls_on = 1'b0;
  int   stall_left = 0;

  rl7_run_length_line_decoder #(
    .LINE_WIDTH(LW),
    .LINE_COUNT(LC)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_code_byte    (in_code_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_color (out_pixel_color),
    .out_run_length  (out_run_length),
    .out_start_column(out_start_column),
    .out_line_row    (out_line_row),
    .out_line_done   (out_line_done),
    .out_frame_done  (out_frame_done)
  );

  always #2 clk = ~clk;

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap(input bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Decodes one accepted byte and queues the run it completes, if any.
  task automatic decode_byte(input logic [rl7_pkg::BYTE_W-1:0] code);
    run_t        run;
    int unsigned left;
    int unsigned len;
    left = LW - col_pos;
    if (awaiting_len) begin
      awaiting_len = 1'b0;
      run.color = held_color;
      len = (code == 0 || int'(code) > left) ? left : int'(code);
    end else if (code[rl7_pkg::RUN_FLAG_BIT]) begin
      held_color = code[rl7_pkg::COLOR_W-1:0];
      awaiting_len = 1'b1;
      return;
    end else begin
      run.color = code[rl7_pkg::COLOR_W-1:0];
      len = 1;
    end
    run.length = rl7_pkg::FIELD_W'(len);
    run.start = rl7_pkg::FIELD_W'(col_pos);
    run.row = rl7_pkg::FIELD_W'(row_pos);
    run.line_done = 1'b0;
    run.frame_done = 1'b0;
    if (col_pos + len >= LW) begin
      col_pos = 0;
      run.line_done = 1'b1;
      lines_predicted++;
      if (row_pos + 1 >= LC) begin
        row_pos = 0;
        run.frame_done = 1'b1;
        frames_predicted++;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos += len;
    end
    expected_runs.push_back(run);
  endtask

  task automatic send_byte(input logic [rl7_pkg::BYTE_W-1:0] code);
    int gap;
    gap = pick_gap(in_gaps_on);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_code_byte <= rl7_pkg::BYTE_W'($urandom);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_code_byte <= code;
    do @(posedge clk); while (!in_ready);
    decode_byte(code);
    bytes_sent++;
  endtask

  task automatic send_run(input logic [rl7_pkg::COLOR_W-1:0] color,
                          input logic [rl7_pkg::BYTE_W-1:0] len);
    send_byte({1'b1, color});
    send_byte(len);
  endtask

  // Receiver side: out_ready drops for random stretches.
  always @(negedge clk) begin
    if (stall_left == 0) stall_left = pick_gap(out_stalls_on);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name, input int unsigned expv,
                                      input int unsigned actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    run_t exp_run;
    if (rst_n && out_valid && out_ready) begin
      if (expected_runs.size() == 0) begin
        $display("%0t: unexpected run beat, color %0d length %0d column %0d row %0d",
                 $time, out_pixel_color, out_run_length, out_start_column, out_line_row);
        errors++;
      end else begin
        exp_run = expected_runs.pop_front();
        check_field("pixel_color", exp_run.color, out_pixel_color);
        check_field("run_length", exp_run.length, out_run_length);
        check_field("start_column", exp_run.start, out_start_column);
        check_field("line_row", exp_run.row, out_line_row);
        check_field("line_done", exp_run.line_done, out_line_done);
        check_field("frame_done", exp_run.frame_done, out_frame_done);
        runs_checked++;
      end
    end
  end

  task automatic test_literal_pixels();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'h55);
    send_byte(8'h2A);
  endtask

  task automatic test_run_lengths();
    send_run(7'h7F, 8'd1);
    // A zero length fills the rest of the line.
    send_run(7'h00, 8'd0);
    // Length bytes with bit 7 set are still plain lengths.
    send_run(7'h05, 8'd200);
    // Only 184 pixels are left, so this run is clipped at the line end.
    send_run(7'h1A, 8'd255);
    // 255 + 128 leaves one column, which a single pixel closes.
    send_run(7'h01, 8'd255);
    send_run(7'h02, 8'd128);
    send_byte(8'h11);
    // 255 + 129 ends exactly at the line end.
    send_run(7'h03, 8'd255);
    send_run(7'h04, 8'd129);
  endtask

  task automatic test_frame_wrap();
    int          frames_at_start;
    int unsigned left;
    frames_at_start = frames_predicted;
    while (frames_predicted == frames_at_start || (col_pos == 0 && row_pos < 3)) begin
      left = LW - col_pos;
      if (left > 255 || $urandom_range(0, 1) == 0)
        send_run(rl7_pkg::COLOR_W'($urandom_range(0, 127)), 8'd0);
      else
        send_run(rl7_pkg::COLOR_W'($urandom_range(0, 127)),
                 rl7_pkg::BYTE_W'($urandom_range(left, 255)));
    end
  endtask

  task automatic random_stream(input int count);
    int                         stop_at;
    int                         r;
    int unsigned                left;
    logic [rl7_pkg::BYTE_W-1:0] len;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 9);
      if (r < 5) begin
        send_byte(rl7_pkg::BYTE_W'($urandom_range(0, 127)));
      end else if (r < 9) begin
        left = LW - col_pos;
        r = $urandom_range(0, 9);
        if (r < 2) len = '0;
        else if (r < 5) len = rl7_pkg::BYTE_W'($urandom_range(1, 15));
        else if (r < 8) len = rl7_pkg::BYTE_W'($urandom_range(0, 255));
        else if (left <= 255) len = rl7_pkg::BYTE_W'($urandom_range(left, 255));
        else len = rl7_pkg::BYTE_W'($urandom_range(128, 255));
        send_run(rl7_pkg::COLOR_W'($urandom_range(0, 127)), len);
      end else begin
        send_byte(rl7_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_random_stream();
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    random_stream(130);
    in_gaps_on = 1'b0;
    random_stream(90);
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b0;
    random_stream(90);
    in_gaps_on = 1'b0;
    random_stream(60);
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    random_stream(60);
  endtask

  task automatic drain();
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_runs.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_runs.size() != 0) begin
      $display("%0t: %0d expected runs never arrived", $time, expected_runs.size());
      errors++;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_literal_pixels();
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    test_run_lengths();
    test_frame_wrap();
    test_random_stream();
    drain();
    $display("Sent %0d code bytes, checked %0d runs over %0d lines and %0d frame wraps.",
             bytes_sent, runs_checked, lines_predicted, frames_predicted);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
